[design/scts_pkg.sv]
// ----------------------------------------------------------------------------
// scts_pkg
// Shared types and protocol constants for the segmented CAN transfer sender.
// ----------------------------------------------------------------------------
`default_nettype none

package scts_pkg;

    localparam int LEN_W       = 8;   // payload length counter
    localparam int POS_W       = 9;   // send position
    localparam int SEQ_W       = 6;   // consecutive frame index
    localparam int TIME_W      = 16;  // millisecond counters
    localparam int ADDR_W      = 8;   // payload store address
    localparam int BANKS       = 8;   // interleaved store banks
    localparam int BANK_W      = 3;
    localparam int ROW_W       = ADDR_W - BANK_W;
    localparam int BANK_ROWS   = 1 << ROW_W;
    localparam int HEAD_N      = 7;   // bytes kept in flops for short frames
    localparam int FRAME_N     = 8;

    localparam int MAX_PAYLOAD_DEF = 255;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [7:0]        PCI_FIRST     = 8'h10;
    localparam logic [7:0]        PCI_FLOW_CTRL = 8'h30;
    localparam logic [SEQ_W-1:0]  SEQ_START     = 6'h21;
    localparam logic [SEQ_W-1:0]  SEQ_WRAP_FROM = 6'h30;
    localparam logic [SEQ_W-1:0]  SEQ_WRAP_TO   = 6'h20;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [LEN_W-1:0]  SF_MAX_LEN    = 8'd7;
    localparam logic [POS_W-1:0]  FF_DATA_LEN   = 9'd6;
    localparam logic [POS_W-1:0]  CF_DATA_LEN   = 9'd7;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] operation;
        t_byte      data_byte;
        logic       data_last;
        t_byte      rx_byte_0;
        t_byte      rx_byte_2;
    } t_item;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_byte             wr_data;
        logic [ADDR_W-1:0] rd_base;
    } t_mem_req;

endpackage

`default_nettype wire

[design/scts_payload_mem.sv]
// ----------------------------------------------------------------------------
// scts_payload_mem
// Payload store as eight interleaved banks; reads seven consecutive bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module scts_payload_mem
    import scts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_byte         o_lane [0:HEAD_N-1]
);

    t_byte             r_bank_q [0:BANKS-1];
    logic [BANK_W-1:0] r_base_lo;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        t_byte             r_mem [0:BANK_ROWS-1];
        logic [BANK_W-1:0] bank_off;
        logic [ADDR_W-1:0] rd_addr;

        // address in [base, base+7] that lands in this bank; the offset wraps
        // within one bank period
        assign bank_off = BANK_W'(b) - i_req.rd_base[BANK_W-1:0];
        assign rd_addr  = i_req.rd_base + {{(ADDR_W-BANK_W){1'b0}}, bank_off};

        always_ff @(posedge i_clk) begin
            if (i_req.wr_en && (i_req.wr_addr[BANK_W-1:0] == BANK_W'(b))) begin
                r_mem[i_req.wr_addr[ADDR_W-1:BANK_W]] <= i_req.wr_data;
            end
            r_bank_q[b] <= r_mem[rd_addr[ADDR_W-1:BANK_W]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_lo <= i_req.rd_base[BANK_W-1:0];
    end

    // rotate banks back into lane order
    always_comb begin
        for (int i = 0; i < HEAD_N; i++) begin
            o_lane[i] = r_bank_q[r_base_lo + BANK_W'(i)];
        end
    end

endmodule

`default_nettype wire

[design/scts_core.sv]
// ----------------------------------------------------------------------------
// scts_core
// Transfer state and frame builder; one item per firing cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scts_core
    import scts_pkg::*;
#(
    parameter int P_MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_item             i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [TIME_W-1:0] i_cfg_data,
    input  wire t_byte             i_lane [0:HEAD_N-1],
    output t_mem_req               o_mem_req,
    output logic                   o_emit,
    output t_byte                  o_frame [0:FRAME_N-1]
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(P_MAX_PAYLOAD);

    logic [LEN_W-1:0]  r_len,     n_len;
    logic [POS_W-1:0]  r_sp,      n_sp;
    logic [SEQ_W-1:0]  r_seq,     n_seq;
    logic              r_busy,    n_busy;
    logic              r_flow,    n_flow;
    t_byte             r_sep,     n_sep;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic [TIME_W-1:0] r_timeout;
    t_byte             r_head  [0:HEAD_N-1];
    t_byte             n_head  [0:HEAD_N-1];
    t_byte             r_frame [0:FRAME_N-1];
    t_byte             n_frame [0:FRAME_N-1];

    logic [LEN_W-1:0]  len_inc;
    logic [TIME_W-1:0] tick_elapsed;
    logic [POS_W-1:0]  remain;
    logic [POS_W-1:0]  cf_count;
    logic [POS_W-1:0]  sp_adv;
    logic [SEQ_W-1:0]  seq_inc;

    always_comb begin
        n_len     = r_len;
        n_sp      = r_sp;
        n_seq     = r_seq;
        n_busy    = r_busy;
        n_flow    = r_flow;
        n_sep     = r_sep;
        n_elapsed = r_elapsed;
        n_head    = r_head;
        n_frame   = r_frame;
        o_emit    = 1'b0;

        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_addr = r_len;
        o_mem_req.wr_data = i_item.data_byte;

        len_inc      = r_len + LEN_W'(1);
        tick_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIME_W'(1);
        remain       = (r_sp < {1'b0, r_len}) ? {1'b0, r_len} - r_sp : '0;
        cf_count     = (remain > CF_DATA_LEN) ? CF_DATA_LEN : remain;
        sp_adv       = r_sp + CF_DATA_LEN;
        seq_inc      = r_seq + SEQ_W'(1);

        if (i_fire) begin
            unique case (i_item.operation)
                OP_LOAD: begin
                    if (!r_busy) begin
                        // append unless the store is full
                        if (r_len < MAX_LEN) begin
                            o_mem_req.wr_en = 1'b1;
                            n_len           = len_inc;
                            if (r_len < LEN_W'(HEAD_N)) begin
                                n_head[r_len[BANK_W-1:0]] = i_item.data_byte;
                            end
                        end
                        if (i_item.data_last) begin
                            n_elapsed = '0;
                            o_emit    = 1'b1;
                            if (n_len <= SF_MAX_LEN) begin
                                n_frame[0] = n_len;
                                for (int i = 0; i < HEAD_N; i++) begin
                                    if (LEN_W'(i) < n_len) begin
                                        n_frame[1+i] = n_head[i];
                                    end
                                end
                                n_len = '0;
                            end else begin
                                n_frame[0] = PCI_FIRST;
                                n_frame[1] = n_len;
                                for (int i = 0; i < int'(FF_DATA_LEN); i++) begin
                                    n_frame[2+i] = n_head[i];
                                end
                                n_sp   = FF_DATA_LEN;
                                n_seq  = SEQ_START;
                                n_busy = 1'b1;
                                n_flow = 1'b0;
                            end
                        end
                    end
                end
                OP_RX: begin
                    if (i_item.rx_byte_0 == PCI_FLOW_CTRL) begin
                        n_flow    = 1'b1;
                        n_sep     = i_item.rx_byte_2;
                        n_elapsed = '0;
                    end
                end
                OP_TICK: begin
                    n_elapsed = tick_elapsed;
                    if (r_busy) begin
                        if (tick_elapsed > r_timeout) begin
                            n_busy = 1'b0;
                            n_flow = 1'b0;
                            n_len  = '0;
                        end else if (r_flow && (tick_elapsed >= {8'd0, r_sep})) begin
                            o_emit     = 1'b1;
                            n_frame[0] = {2'b00, r_seq};
                            for (int i = 0; i < HEAD_N; i++) begin
                                if (POS_W'(i) < cf_count) begin
                                    n_frame[1+i] = i_lane[i];
                                end
                            end
                            n_sp = sp_adv;
                            if (sp_adv >= {1'b0, r_len}) begin
                                n_busy = 1'b0;
                                n_flow = 1'b0;
                                n_len  = '0;
                            end else begin
                                n_seq     = (seq_inc == SEQ_WRAP_FROM) ? SEQ_WRAP_TO
                                                                       : seq_inc;
                                n_elapsed = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // prefetch the window for the position that holds after this cycle
        o_mem_req.rd_base = n_sp[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_sp      <= '0;
            r_seq     <= '0;
            r_busy    <= 1'b0;
            r_flow    <= 1'b0;
            r_sep     <= '0;
            r_elapsed <= '0;
            r_timeout <= TIMEOUT_RESET;
            for (int i = 0; i < FRAME_N; i++) begin
                r_frame[i] <= '0;
            end
        end else begin
            r_len     <= n_len;
            r_sp      <= n_sp;
            r_seq     <= n_seq;
            r_busy    <= n_busy;
            r_flow    <= n_flow;
            r_sep     <= n_sep;
            r_elapsed <= n_elapsed;
            r_frame   <= n_frame;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    assign o_frame = r_frame;

endmodule

`default_nettype wire

[design/segmented_can_transfer_sender_top.sv]
// ----------------------------------------------------------------------------
// segmented_can_transfer_sender_top
// Sending side of segmented CAN transport: single, first and consecutive
// frames built from a loaded payload, paced by flow control and ms ticks.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_operation .. i_rx_byte_2
//   result    out        o_out_valid / i_out_stall o_frame_byte_0 .. _7
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_data (timeout_ms)
//
// One request is accepted per cycle while the input is not stalled. A request
// is held in the input register, then the core updates state and the frame
// register in a single pass; with no result stall, a frame's valid rises at
// the edge after the one that accepts its request.
// The payload store read is registered; the core prefetches the next
// consecutive-frame window, so no request waits on the store.
// Synchronous active-low reset clears control state; the store needs none.
// A stalled result holds the frame register, and the input stalls only while
// its registered request cannot move into a busy result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_can_transfer_sender_top
    import scts_pkg::*;
#(
    parameter int P_MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_data_last,
    input  wire logic [7:0]  i_rx_byte_0,
    input  wire logic [7:0]  i_rx_byte_1,
    input  wire logic [7:0]  i_rx_byte_2,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_frame_byte_0,
    output logic [7:0]       o_frame_byte_1,
    output logic [7:0]       o_frame_byte_2,
    output logic [7:0]       o_frame_byte_3,
    output logic [7:0]       o_frame_byte_4,
    output logic [7:0]       o_frame_byte_5,
    output logic [7:0]       o_frame_byte_6,
    output logic [7:0]       o_frame_byte_7,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic     r_in_valid;
    t_item    r_in;
    logic     r_out_valid;
    logic     fire;
    logic     accept;
    logic     emit;
    t_mem_req mem_req;
    t_byte    lane  [0:HEAD_N-1];
    t_byte    frame [0:FRAME_N-1];

    // Advance the registered request when the result slot is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    // The block-size byte is accepted and dropped; nothing uses it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.operation <= i_operation;
            r_in.data_byte <= i_data_byte;
            r_in.data_last <= i_data_last;
            r_in.rx_byte_0 <= i_rx_byte_0;
            r_in.rx_byte_2 <= i_rx_byte_2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            // A firing request either posts a frame or leaves the slot empty.
            if (fire) begin
                r_out_valid <= emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes land at once; the host must write only while idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    scts_core #(
        .P_MAX_PAYLOAD (P_MAX_PAYLOAD)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_lane     (lane),
        .o_mem_req  (mem_req),
        .o_emit     (emit),
        .o_frame    (frame)
    );

    scts_payload_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_lane (lane)
    );

    assign o_out_valid    = r_out_valid;
    assign o_frame_byte_0 = frame[0];
    assign o_frame_byte_1 = frame[1];
    assign o_frame_byte_2 = frame[2];
    assign o_frame_byte_3 = frame[3];
    assign o_frame_byte_4 = frame[4];
    assign o_frame_byte_5 = frame[5];
    assign o_frame_byte_6 = frame[6];
    assign o_frame_byte_7 = frame[7];

endmodule

`default_nettype wire
